/* rtl/trace_record_ring_buffer_core_defines.svh */
// ----------------------------------------------------------------------------
// Trace record ring buffer assertion macros
// Shared property forms for the trace ring top level.
// ----------------------------------------------------------------------------
`ifndef TRACE_RECORD_RING_BUFFER_CORE_DEFINES_SVH
`define TRACE_RECORD_RING_BUFFER_CORE_DEFINES_SVH

// same-cycle implication
`define TRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/trb_pkg.sv */
// ----------------------------------------------------------------------------
// Trace record ring buffer package
// Types and codes shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trb_pkg;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_INVALID   = 2'd1,
    STS_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CALC,
    ST_RUN,
    ST_FETCH,
    ST_BLANK
  } state_t;

  typedef struct packed {
    logic [63:0] e_time;
    logic [7:0]  e_cpu;
    logic [31:0] e_cat;
    logic [63:0] e_obj;
    logic [63:0] e_first;
    logic [63:0] e_second;
  } entry_t;

  typedef struct packed {
    logic in_ready;
    logic accept_store;
    logic latch_read;
    logic setup;
    logic calc;
    logic rd_issue;
    logic emit_entry;
    logic emit_blank;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_req_type;
    logic out_free;
    logic resume_all1;
    logic run_empty;
    logic last_entry;
  } dp_sts_t;

endpackage

/* rtl/trb_if.sv */
// ----------------------------------------------------------------------------
// Trace record ring buffer channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface trb_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] event_category;
  logic [63:0] event_object;
  logic [63:0] first_value;
  logic [63:0] second_value;
  logic [63:0] event_time;
  logic [7:0]  source_cpu;
  logic [63:0] resume_after;
  logic [6:0]  read_limit;

  modport source (
    output valid, req_type, event_category, event_object, first_value,
           second_value, event_time, source_cpu, resume_after, read_limit,
    input  ready
  );
  modport sink (
    input  valid, req_type, event_category, event_object, first_value,
           second_value, event_time, source_cpu, resume_after, read_limit,
    output ready
  );
endinterface

interface trb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_status;
  logic        has_entry;
  logic        last_of_run;
  logic [63:0] entry_seq;
  logic [63:0] entry_time;
  logic [7:0]  entry_cpu;
  logic [31:0] entry_category;
  logic [63:0] entry_object;
  logic [63:0] entry_first;
  logic [63:0] entry_second;
  logic [63:0] newest_seq;

  modport source (
    output valid, out_status, has_entry, last_of_run, entry_seq, entry_time,
           entry_cpu, entry_category, entry_object, entry_first, entry_second,
           newest_seq,
    input  ready
  );
  modport sink (
    input  valid, out_status, has_entry, last_of_run, entry_seq, entry_time,
           entry_cpu, entry_category, entry_object, entry_first, entry_second,
           newest_seq,
    output ready
  );
endinterface

/* rtl/trb_ctrl.sv */
// ----------------------------------------------------------------------------
// Trace record ring buffer controller
// Sequences store requests and read runs through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trb_ctrl
  import trb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = sts.out_free;
        if (sts.in_valid && sts.out_free) begin
          if (sts.in_req_type == REQ_READ) begin
            cmd.latch_read = 1'b1;
            state_next     = ST_SETUP;
          end else begin
            cmd.accept_store = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        if (sts.resume_all1) begin
          state_next = ST_BLANK;
        end else begin
          cmd.setup  = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (sts.run_empty) begin
          state_next = ST_BLANK;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          state_next     = sts.last_entry ? ST_IDLE : ST_RUN;
        end
      end
      ST_BLANK: begin
        if (sts.out_free) begin
          cmd.emit_blank = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/trb_dp.sv */
// ----------------------------------------------------------------------------
// Trace record ring buffer datapath
// Record memory, sequence counter, read run registers and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trb_dp
  import trb_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  trb_in_if.sink        req,
  trb_out_if.source     rsp,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  entry_t mem [RING_DEPTH];
  entry_t rd_data;

  logic [63:0]   write_count;
  logic [AW-1:0] wr_slot;
  logic [63:0]   rq_resume;
  logic [CW-1:0] rq_limit;
  logic [63:0]   cur_seq;
  logic [CW-1:0] remaining;
  logic [AW-1:0] rd_slot;

  logic          out_valid;
  status_t       out_status;
  logic          out_has;
  logic          out_last;
  logic [63:0]   out_seq;
  entry_t        out_entry;
  logic [63:0]   out_newest;

  // store decode
  logic    wc_all1;
  status_t st_code;
  entry_t  wr_entry;

  // read run setup
  logic [63:0] oldest;
  logic [63:0] resume_p1;
  logic [63:0] span64;
  logic [CW-1:0] span;
  logic [CW:0]   wr_ext;
  logic [CW:0]   sp_ext;
  logic [CW:0]   slot_calc;
  logic          out_load;

  assign wc_all1 = &write_count;

  always_comb begin
    if (req.event_category == 32'd0) begin
      st_code = STS_INVALID;
    end else if (wc_all1) begin
      st_code = STS_EXHAUSTED;
    end else begin
      st_code = STS_OK;
    end
  end

  assign wr_entry.e_time   = req.event_time;
  assign wr_entry.e_cpu    = req.source_cpu;
  assign wr_entry.e_cat    = req.event_category;
  assign wr_entry.e_obj    = req.event_object;
  assign wr_entry.e_first  = req.first_value;
  assign wr_entry.e_second = req.second_value;

  assign oldest    = (write_count >= 64'(RING_DEPTH)) ?
                     write_count - 64'(RING_DEPTH - 1) : 64'd1;
  assign resume_p1 = rq_resume + 64'd1;

  // span from the first wanted sequence to the newest never exceeds the depth when that sequence is not past the newest
  assign span64    = write_count - cur_seq + 64'd1;
  assign span      = span64[CW-1:0];
  assign wr_ext    = (CW+1)'(wr_slot);
  assign sp_ext    = (CW+1)'(span);
  assign slot_calc = (wr_ext >= sp_ext) ? wr_ext - sp_ext
                                        : wr_ext + (CW+1)'(RING_DEPTH) - sp_ext;

  // Entries written since reset are the only ones a run can reach, so every
  // slot a run reads holds a written record and the store needs no clearing pass.
  always_ff @(posedge clk) begin
    if (cmd.accept_store && st_code == STS_OK) begin
      mem[wr_slot] <= wr_entry;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      wr_slot     <= '0;
    end else if (cmd.accept_store && st_code == STS_OK) begin
      write_count <= write_count + 64'd1;
      wr_slot     <= (wr_slot == AW'(RING_DEPTH - 1)) ? '0 : wr_slot + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_read) begin
      rq_resume <= req.resume_after;
      rq_limit  <= (req.read_limit > 7'(RING_DEPTH)) ? CW'(RING_DEPTH)
                                                      : CW'(req.read_limit);
    end
    if (cmd.setup) begin
      cur_seq <= (resume_p1 > oldest) ? resume_p1 : oldest;
    end
    if (cmd.calc) begin
      if (cur_seq > write_count) begin
        remaining <= '0;
      end else begin
        remaining <= (rq_limit < span) ? rq_limit : span;
      end
      rd_slot <= slot_calc[AW-1:0];
    end
    if (cmd.emit_entry) begin
      cur_seq   <= cur_seq + 64'd1;
      remaining <= remaining - CW'(1);
      rd_slot   <= (rd_slot == AW'(RING_DEPTH - 1)) ? '0 : rd_slot + AW'(1);
    end
  end

  assign out_load = cmd.accept_store || cmd.emit_entry || cmd.emit_blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_store) begin
      out_status <= st_code;
      out_has    <= 1'b0;
      out_last   <= 1'b1;
      out_seq    <= '0;
      out_entry  <= '0;
      out_newest <= (st_code == STS_OK) ? write_count + 64'd1 : write_count;
    end else if (cmd.emit_entry) begin
      out_status <= STS_OK;
      out_has    <= 1'b1;
      out_last   <= (remaining == CW'(1));
      out_seq    <= cur_seq;
      out_entry  <= rd_data;
      out_newest <= write_count;
    end else if (cmd.emit_blank) begin
      out_status <= STS_OK;
      out_has    <= 1'b0;
      out_last   <= 1'b1;
      out_seq    <= '0;
      out_entry  <= '0;
      out_newest <= write_count;
    end
  end

  assign req.ready          = cmd.in_ready;
  assign rsp.valid          = out_valid;
  assign rsp.out_status     = out_status;
  assign rsp.has_entry      = out_has;
  assign rsp.last_of_run    = out_last;
  assign rsp.entry_seq      = out_seq;
  assign rsp.entry_time     = out_entry.e_time;
  assign rsp.entry_cpu      = out_entry.e_cpu;
  assign rsp.entry_category = out_entry.e_cat;
  assign rsp.entry_object   = out_entry.e_obj;
  assign rsp.entry_first    = out_entry.e_first;
  assign rsp.entry_second   = out_entry.e_second;
  assign rsp.newest_seq     = out_newest;

  assign sts.in_valid    = req.valid;
  assign sts.in_req_type = req.req_type;
  assign sts.out_free    = !out_valid || rsp.ready;
  assign sts.resume_all1 = &rq_resume;
  assign sts.run_empty   = (remaining == '0);
  assign sts.last_entry  = (remaining == CW'(1));

endmodule

/* rtl/trace_record_ring_buffer_core.sv */
// ----------------------------------------------------------------------------
// Trace record ring buffer core
// Overwriting ring of sequence-tagged trace records with resumable reads.
// ----------------------------------------------------------------------------
// A store request returns one word carrying its status and the newest
// sequence. A read request sets up its run (latch, start sequence, run length
// and start slot), then reads and returns its entries one at a time, bounded
// by the one registered read port of the record memory; a read that asks for
// the newest sequence only, or whose run turns out empty, gives a single word
// with no entry. A new request is taken only when the previous one is
// finished and the output word is free or being taken. The record memory holds
// RING_DEPTH entries and needs no clearing pass.
`timescale 1ns / 1ps

`include "trace_record_ring_buffer_core_defines.svh"

module trace_record_ring_buffer_core
  import trb_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  trb_in_if.sink     req,
  trb_out_if.source  rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  trb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  trb_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

  `TRB_ASSERT_NOW(a_accept_needs_room, req.valid && req.ready, !rsp.valid || rsp.ready, "request taken while output word blocked")
  `TRB_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.accept_store, cmd.latch_read, cmd.setup, cmd.calc, cmd.rd_issue, cmd.emit_entry, cmd.emit_blank}), "more than one datapath command")
  `TRB_ASSERT_NEXT(a_read_no_word, cmd.latch_read, !cmd.in_ready, "new request taken during read setup")

endmodule

/* verif/trace_ring_scoreboard.sv */
// ----------------------------------------------------------------------------
// Trace ring scoreboard
// Watches the request and response channels of the trace ring, keeps its own
// copy of the record store and sequence counter, and checks each response
// word field by field against the words that the accepted requests predict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trace_ring_scoreboard
  import trb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  trb_in_if    req,
  trb_out_if   rsp,
  output int   mismatches,
  output int   outstanding,
  output int   entry_words
);

  typedef struct {
    status_t     status;
    logic        has_entry;
    logic        last;
    logic [63:0] seq;
    entry_t      rec;
    logic [63:0] newest;
  } trace_word_t;

  entry_t      kept_rec [DEPTH];
  logic [63:0] kept_tag [DEPTH];
  logic [63:0] last_seq;
  trace_word_t words_due [$];
  int          words_checked;

  function automatic trace_word_t blank_word(status_t st);
    trace_word_t w;
    w.status    = st;
    w.has_entry = 1'b0;
    w.last      = 1'b1;
    w.seq       = '0;
    w.rec       = '0;
    w.newest    = last_seq;
    return w;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want)
      report($sformatf("word %0d %s: expected %h, got %h", words_checked, name, want, got));
  endtask

  // Updates the store and queues the response words of one accepted request.
  task automatic apply_trace_request();
    logic [63:0] newest;
    logic [63:0] start;
    logic [63:0] s;
    int          lim;
    int          slot;
    trace_word_t run [$];
    trace_word_t w;
    if (req.req_type == REQ_STORE) begin
      if (req.event_category == '0) begin
        words_due.push_back(blank_word(STS_INVALID));
      end else if (last_seq == '1) begin
        words_due.push_back(blank_word(STS_EXHAUSTED));
      end else begin
        last_seq = last_seq + 64'd1;
        slot = int'((last_seq - 64'd1) % DEPTH);
        kept_rec[slot] = '{e_time: req.event_time, e_cpu: req.source_cpu,
                           e_cat: req.event_category, e_obj: req.event_object,
                           e_first: req.first_value, e_second: req.second_value};
        kept_tag[slot] = last_seq;
        words_due.push_back(blank_word(STS_OK));
      end
    end else if (req.resume_after == '1) begin
      words_due.push_back(blank_word(STS_OK));
    end else begin
      newest = last_seq;
      lim = (req.read_limit > DEPTH) ? DEPTH : int'(req.read_limit);
      start = (newest >= DEPTH) ? newest - DEPTH + 64'd1 : 64'd1;
      if (req.resume_after + 64'd1 > start) start = req.resume_after + 64'd1;
      s = start;
      while (s <= newest && run.size() < lim) begin
        slot = int'((s - 64'd1) % DEPTH);
        // slot is current only if its tag still belongs to this sequence
        if (kept_tag[slot] == s) begin
          w.status    = STS_OK;
          w.has_entry = 1'b1;
          w.last      = 1'b0;
          w.seq       = s;
          w.rec       = kept_rec[slot];
          w.newest    = newest;
          run.push_back(w);
        end
        if (s == newest) break;
        s++;
      end
      if (run.size() == 0) begin
        words_due.push_back(blank_word(STS_OK));
      end else begin
        foreach (run[i]) begin
          w = run[i];
          w.last = (i == run.size() - 1);
          words_due.push_back(w);
        end
      end
    end
  endtask

  task automatic check_word();
    trace_word_t w;
    if (words_due.size() == 0) begin
      report($sformatf("word with nothing expected: status %0d entry %0b seq %0d",
                       rsp.out_status, rsp.has_entry, rsp.entry_seq));
      return;
    end
    w = words_due.pop_front();
    if (w.has_entry) entry_words++;
    cmp_field("out_status",     w.status,       rsp.out_status);
    cmp_field("has_entry",      w.has_entry,    rsp.has_entry);
    cmp_field("last_of_run",    w.last,         rsp.last_of_run);
    cmp_field("entry_seq",      w.seq,          rsp.entry_seq);
    cmp_field("entry_time",     w.rec.e_time,   rsp.entry_time);
    cmp_field("entry_cpu",      w.rec.e_cpu,    rsp.entry_cpu);
    cmp_field("entry_category", w.rec.e_cat,    rsp.entry_category);
    cmp_field("entry_object",   w.rec.e_obj,    rsp.entry_object);
    cmp_field("entry_first",    w.rec.e_first,  rsp.entry_first);
    cmp_field("entry_second",   w.rec.e_second, rsp.entry_second);
    cmp_field("newest_seq",     w.newest,       rsp.newest_seq);
    words_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        kept_rec[i] = '0;
        kept_tag[i] = '0;
      end
      last_seq = '0;
      words_due.delete();
      words_checked = 0;
      mismatches = 0;
      entry_words = 0;
    end else begin
      // response first: a word leaving now cannot belong to a request taken now
      if (rsp.valid && rsp.ready) check_word();
      if (req.valid && req.ready) apply_trace_request();
    end
    outstanding <= words_due.size();
  end

endmodule

/* verif/trace_record_ring_buffer_core_tb.sv */
// ----------------------------------------------------------------------------
// Trace record ring buffer testbench
// Drives store and read requests into the trace ring with random gaps and
// output stalls, including a long output hold-off and a drain pause, and
// lets the scoreboard check every response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trace_record_ring_buffer_core_tb
  import trb_pkg::*;
();

  localparam int DEPTH     = 64;
  localparam int LONG_HOLD = 250;

  typedef struct {
    req_t        kind;
    logic [31:0] cat;
    logic [63:0] obj;
    logic [63:0] first;
    logic [63:0] second;
    logic [63:0] stamp;
    logic [7:0]  cpu;
    logic [63:0] resume;
    logic [6:0]  limit;
  } trace_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          mismatches;
  int          outstanding;
  int          entry_words;
  bit          quiet = 1'b0;
  bit          long_hold_pending = 1'b0;
  bit          long_hold_active = 1'b0;
  logic [63:0] issued_seq = '0;
  int          n_store = 0;
  int          n_reject = 0;
  int          n_read = 0;

  trb_in_if  req_ch ();
  trb_out_if rsp_ch ();

  trace_record_ring_buffer_core #(.RING_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  trace_ring_scoreboard #(.DEPTH(DEPTH)) ring_sb (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .entry_words (entry_words)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // every field random, whether the request uses it or not
  function automatic trace_req_t noise_req(req_t kind);
    trace_req_t r;
    r.kind   = kind;
    r.cat    = $urandom;
    r.obj    = rand64();
    r.first  = rand64();
    r.second = rand64();
    r.stamp  = rand64();
    r.cpu    = 8'($urandom_range(0, 255));
    r.resume = rand64();
    r.limit  = 7'($urandom_range(0, DEPTH));
    return r;
  endfunction

  function automatic trace_req_t random_req();
    trace_req_t r;
    r = noise_req(($urandom_range(0, 99) < 55) ? REQ_STORE : REQ_READ);
    if (r.kind == REQ_STORE) begin
      if ($urandom_range(0, 9) == 0) r.cat = '0;
    end else begin
      case ($urandom_range(0, 11))
        0:       r.resume = '1;
        1:       ;  // far-off resume point, mostly an empty run
        2:       r.resume = '0;
        default: r.resume = issued_seq - $urandom_range(0, DEPTH + 8);
      endcase
      case ($urandom_range(0, 7))
        0:       r.limit = '0;
        1:       r.limit = 7'(DEPTH);
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic offer(trace_req_t r);
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= r.kind;
    req_ch.event_category <= r.cat;
    req_ch.event_object   <= r.obj;
    req_ch.first_value    <= r.first;
    req_ch.second_value   <= r.second;
    req_ch.event_time     <= r.stamp;
    req_ch.source_cpu     <= r.cpu;
    req_ch.resume_after   <= r.resume;
    req_ch.read_limit     <= r.limit;
    do @(posedge clk); while (!req_ch.ready);
    if (r.kind == REQ_STORE) begin
      n_store++;
      if (r.cat == '0) n_reject++;
      else if (issued_seq != '1) issued_seq++;
    end else begin
      n_read++;
    end
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      offer(random_req());
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // response side: random stalls, one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        long_hold_active  = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_active = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    trace_req_t r;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_STORE;
    req_ch.event_category <= '0;
    req_ch.event_object   <= '0;
    req_ch.first_value    <= '0;
    req_ch.second_value   <= '0;
    req_ch.event_time     <= '0;
    req_ch.source_cpu     <= '0;
    req_ch.resume_after   <= '0;
    req_ch.read_limit     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty ring: full-limit read, then newest only
    r = noise_req(REQ_READ);
    r.resume = '0;
    r.limit  = 7'(DEPTH);
    offer(r);
    r.resume = '1;
    offer(r);
    // zero category is rejected
    r = noise_req(REQ_STORE);
    r.cat = '0;
    offer(r);
    // all-ones and all-zero record fields
    r.cat    = '1;
    r.obj    = '1;
    r.first  = '1;
    r.second = '1;
    r.stamp  = '1;
    r.cpu    = '1;
    offer(r);
    r.cat    = 32'd1;
    r.obj    = '0;
    r.first  = '0;
    r.second = '0;
    r.stamp  = '0;
    r.cpu    = '0;
    offer(r);
    repeat (4) begin
      r = noise_req(REQ_STORE);
      r.cat[0] = 1'b1;
      offer(r);
    end
    // read runs: full, zero limit, single word, partial, nothing newer
    r = noise_req(REQ_READ);
    r.resume = '0;
    r.limit  = 7'(DEPTH);
    offer(r);
    r.limit = '0;
    offer(r);
    r.limit = 7'd1;
    offer(r);
    r.resume = 64'd2;
    r.limit  = 7'd3;
    offer(r);
    r.resume = issued_seq;
    r.limit  = 7'(DEPTH);
    offer(r);
    r.resume = '1 - 64'd1;
    offer(r);
    r.resume = '1;
    offer(r);

    run_random(140);

    // output held off while requests keep coming: block must back up
    req_ch.valid <= 1'b0;
    long_hold_pending = 1'b1;
    wait (long_hold_active);
    repeat (8) offer(random_req());
    drain();

    run_random(120);
    quiet = 1'b1;
    run_random(45);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d stores (%0d with category zero) and %0d reads, %0d entry words",
             n_store, n_reject, n_read, entry_words);
    $display("sequence reached %0d (ring wrapped %0d times), with long stall and drain pause",
             issued_seq, issued_seq / DEPTH);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
